### rtl/rebd_pkg.sv
// rebd_pkg: shared types, constants and the quadrature lookup for the
// rotary encoder and button decoder. No dependencies.

package rebd_pkg;

  // default timestamp width in bits
  localparam int unsigned TimeWidthDef = 32;

  // widths fixed by the port definition
  localparam int unsigned NowWidth     = 32;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned MsWidth      = 16;
  localparam int unsigned ThrWidth     = 4;
  localparam int unsigned StepCntWidth = 5;

  // register reset values
  localparam logic [MsWidth-1:0]  StepIntervalRst = 16'd80;
  localparam logic [MsWidth-1:0]  DebounceRst     = 16'd50;
  localparam logic [MsWidth-1:0]  ClickMaxRst     = 16'd500;
  localparam logic [MsWidth-1:0]  LongPressRst    = 16'd800;
  localparam logic [MsWidth-1:0]  DoubleClickRst  = 16'd400;
  localparam logic [ThrWidth-1:0] StepThrRst      = 4'd4;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_STEP_INTERVAL = 3'd0,
    CFG_DEBOUNCE      = 3'd1,
    CFG_CLICK_MAX     = 3'd2,
    CFG_LONG_PRESS    = 3'd3,
    CFG_DOUBLE_CLICK  = 3'd4,
    CFG_STEP_THRESH   = 3'd5
  } cfg_idx_e;

  // direction codes, two bit signed
  localparam logic signed [1:0] DirNone = 2'sb00;
  localparam logic signed [1:0] DirCw   = 2'sb01;
  localparam logic signed [1:0] DirCcw  = 2'sb11;

  // encoder pin levels after reset: both high
  localparam logic [1:0] EncIdle = 2'b11;

  // configuration bundle handed to the decoders
  typedef struct packed {
    logic [MsWidth-1:0]  step_interval;
    logic [MsWidth-1:0]  debounce;
    logic [MsWidth-1:0]  click_max;
    logic [MsWidth-1:0]  long_press;
    logic [MsWidth-1:0]  double_click;
    logic [ThrWidth-1:0] step_thresh;
  } cfg_t;

  // single-bit fields of one registered request
  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic button;
    logic read_events;
  } item_t;

  // button events of one request
  typedef struct packed {
    logic clicked;
    logic long_press;
    logic double_click;
  } btn_evt_t;

  // quadrature delta for {previous pins, current pins}
  function automatic logic signed [1:0] gray_delta(input logic [3:0] idx);
    logic signed [1:0] d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/rebd_cfg_regs.sv
// rebd_cfg_regs: configuration register file of the encoder/button decoder.
// Depends on rebd_pkg.

module rebd_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rebd_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [rebd_pkg::CfgDataWidth-1:0] cfg_data_i,
  output rebd_pkg::cfg_t                    cfg_o
);
  import rebd_pkg::*;

  cfg_t cfg_q, cfg_d;

  // the register file never pushes back
  assign cfg_ready_o = 1'b1;

  // write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_STEP_INTERVAL: cfg_d.step_interval = cfg_data_i;
        CFG_DEBOUNCE:      cfg_d.debounce      = cfg_data_i;
        CFG_CLICK_MAX:     cfg_d.click_max     = cfg_data_i;
        CFG_LONG_PRESS:    cfg_d.long_press    = cfg_data_i;
        CFG_DOUBLE_CLICK:  cfg_d.double_click  = cfg_data_i;
        CFG_STEP_THRESH:   cfg_d.step_thresh   = cfg_data_i[ThrWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_interval <= StepIntervalRst;
      cfg_q.debounce      <= DebounceRst;
      cfg_q.click_max     <= ClickMaxRst;
      cfg_q.long_press    <= LongPressRst;
      cfg_q.double_click  <= DoubleClickRst;
      cfg_q.step_thresh   <= StepThrRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/rebd_quad.sv
// rebd_quad: quadrature count, step threshold and rate limit, latched direction.
// Depends on rebd_pkg.

module rebd_quad #(
  parameter int unsigned TIME_WIDTH = rebd_pkg::TimeWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   pin_a_i,
  input  logic                   pin_b_i,
  input  logic                   rd_i,
  input  logic [TIME_WIDTH-1:0]  now_i,
  input  rebd_pkg::cfg_t         cfg_i,
  output logic signed [1:0]      dir_o
);
  import rebd_pkg::*;

  logic [1:0]                     prev_q;
  logic signed [StepCntWidth-1:0] cnt_q, cnt_d, cnt_sum;
  logic [TIME_WIDTH-1:0]          last_step_q, last_step_d, el_step;
  logic signed [1:0]              dir_q, dir_d, delta;
  logic [ThrWidth-1:0]            thr;
  logic signed [StepCntWidth-1:0] thr_s;
  logic                           hit;

  // table lookup and accumulate
  assign delta   = gray_delta({prev_q, pin_a_i, pin_b_i});
  assign cnt_sum = cnt_q + StepCntWidth'(delta);

  // a zero threshold acts as one
  assign thr   = (cfg_i.step_thresh == '0) ? ThrWidth'(1) : cfg_i.step_thresh;
  assign thr_s = $signed({1'b0, thr});
  assign hit   = (cnt_sum >= thr_s) || (cnt_sum <= -thr_s);

  assign el_step = now_i - last_step_q;

  // step detection with minimum interval
  always_comb begin
    cnt_d       = cnt_sum;
    last_step_d = last_step_q;
    dir_d       = dir_q;
    if (hit) begin
      if (el_step >= TIME_WIDTH'(cfg_i.step_interval)) begin
        last_step_d = now_i;
        dir_d       = (cnt_sum > 0) ? DirCw : DirCcw;
      end
      cnt_d = '0;
    end
  end

  assign dir_o = dir_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= EncIdle;
      cnt_q       <= '0;
      last_step_q <= '0;
      dir_q       <= DirNone;
    end else if (adv_i) begin
      prev_q      <= {pin_a_i, pin_b_i};
      cnt_q       <= cnt_d;
      last_step_q <= last_step_d;
      dir_q       <= rd_i ? DirNone : dir_d;
    end
  end

  // a read request leaves no pending step behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && rd_i) |=> (dir_q == DirNone))
    else $error("pending direction survived a read");

endmodule

### rtl/rebd_button.sv
// rebd_button: button debounce and click / long press / double click latches.
// Depends on rebd_pkg.

module rebd_button #(
  parameter int unsigned TIME_WIDTH = rebd_pkg::TimeWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  button_i,
  input  logic                  rd_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  rebd_pkg::cfg_t        cfg_i,
  output rebd_pkg::btn_evt_t    evt_o
);
  import rebd_pkg::*;

  logic                  stable_q, stable_d;
  logic [TIME_WIDTH-1:0] last_chg_q, last_chg_d;
  logic [TIME_WIDTH-1:0] press_q, press_d;
  logic [TIME_WIDTH-1:0] last_press_q, last_press_d;
  logic                  long_fired_q, long_fired_d;
  logic                  suppress_q, suppress_d;
  btn_evt_t              flags_q, flags_d;
  logic [TIME_WIDTH-1:0] el_chg, el_press_old, el_last_press, el_press_new;

  assign el_chg        = now_i - last_chg_q;
  assign el_press_old  = now_i - press_q;
  assign el_last_press = now_i - last_press_q;
  assign el_press_new  = now_i - press_d;

  // debounced edge handling
  always_comb begin
    stable_d     = stable_q;
    last_chg_d   = last_chg_q;
    press_d      = press_q;
    last_press_d = last_press_q;
    long_fired_d = long_fired_q;
    suppress_d   = suppress_q;
    flags_d      = flags_q;
    if ((button_i != stable_q) && (el_chg >= TIME_WIDTH'(cfg_i.debounce))) begin
      last_chg_d = now_i;
      stable_d   = button_i;
      if (!button_i) begin
        // press edge
        press_d      = now_i;
        long_fired_d = 1'b0;
        if (el_last_press < TIME_WIDTH'(cfg_i.double_click)) begin
          flags_d.double_click = 1'b1;
          flags_d.clicked      = 1'b0;
          suppress_d           = 1'b1;
        end
        last_press_d = now_i;
      end else begin
        // release edge
        if (!long_fired_q && (el_press_old < TIME_WIDTH'(cfg_i.click_max))) begin
          if (!suppress_q) begin
            flags_d.clicked = 1'b1;
          end
          suppress_d = 1'b0;
        end
        long_fired_d = 1'b0;
      end
    end
    // long press while held
    if (!stable_d && !long_fired_d && (el_press_new >= TIME_WIDTH'(cfg_i.long_press))) begin
      flags_d.long_press = 1'b1;
      long_fired_d       = 1'b1;
    end
  end

  assign evt_o = flags_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q     <= 1'b1;
      last_chg_q   <= '0;
      press_q      <= '0;
      last_press_q <= '0;
      long_fired_q <= 1'b0;
      suppress_q   <= 1'b0;
      flags_q      <= '0;
    end else if (adv_i) begin
      stable_q     <= stable_d;
      last_chg_q   <= last_chg_d;
      press_q      <= press_d;
      last_press_q <= last_press_d;
      long_fired_q <= long_fired_d;
      suppress_q   <= suppress_d;
      flags_q      <= rd_i ? '0 : flags_d;
    end
  end

  // a long press can only be marked while the button is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_fired_q |-> !stable_q)
    else $error("long press marked while released");

  // a read request clears every latched event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && rd_i) |=> (flags_q == '0))
    else $error("button events survived a read");

endmodule

### rtl/rotary_encoder_button_decoder.sv
// rotary_encoder_button_decoder: top level, input register, decoders, result register.
// Depends on rebd_pkg, rebd_cfg_regs, rebd_quad, rebd_button.

// Accepts one request per clock while not stalled and returns exactly
// one result per request. The request is captured in an input register at
// the accepting edge. The encoder and button state then update through
// table lookup, timestamp subtracts and compares, and the result lands in
// an output register when the input register advances. The state
// recurrence closes through the state registers alone, so throughput is
// one request per clock whenever the result side is not stalled; a stall
// on the result side holds the output register and then the input
// register. Results carry zero fields unless the request asks to read
// events, in which case latched events are returned and cleared.
// Configuration writes are always ready and must only be issued while no
// request is in flight.

module rotary_encoder_button_decoder #(
  parameter int unsigned TIME_WIDTH = rebd_pkg::TimeWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              pin_a_i,
  input  logic                              pin_b_i,
  input  logic                              button_level_i,
  input  logic [rebd_pkg::NowWidth-1:0]     now_ms_i,
  input  logic                              read_events_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [1:0]                 direction_o,
  output logic                              clicked_o,
  output logic                              long_press_o,
  output logic                              double_click_o,
  // configuration channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rebd_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [rebd_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import rebd_pkg::*;

  cfg_t                  cfg;
  logic                  s1_valid_q;
  item_t                 s1_item_q;
  logic [TIME_WIDTH-1:0] s1_now_q;
  logic                  out_valid_q;
  logic signed [1:0]     out_dir_q;
  btn_evt_t              out_evt_q;
  logic                  out_ready, adv, in_take;
  logic signed [1:0]     dir;
  btn_evt_t              evt;

  // pipeline control
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  rebd_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.pin_a       <= pin_a_i;
      s1_item_q.pin_b       <= pin_b_i;
      s1_item_q.button      <= button_level_i;
      s1_item_q.read_events <= read_events_i;
      s1_now_q              <= TIME_WIDTH'(now_ms_i);
    end
  end

  rebd_quad #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_quad (
    .clk_i,
    .rst_ni,
    .adv_i   (adv),
    .pin_a_i (s1_item_q.pin_a),
    .pin_b_i (s1_item_q.pin_b),
    .rd_i    (s1_item_q.read_events),
    .now_i   (s1_now_q),
    .cfg_i   (cfg),
    .dir_o   (dir)
  );

  rebd_button #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_button (
    .clk_i,
    .rst_ni,
    .adv_i    (adv),
    .button_i (s1_item_q.button),
    .rd_i     (s1_item_q.read_events),
    .now_i    (s1_now_q),
    .cfg_i    (cfg),
    .evt_o    (evt)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_dir_q <= s1_item_q.read_events ? dir : DirNone;
      out_evt_q <= s1_item_q.read_events ? evt : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign direction_o    = out_dir_q;
  assign clicked_o      = out_evt_q.clicked;
  assign long_press_o   = out_evt_q.long_press;
  assign double_click_o = out_evt_q.double_click;

  // the request side only backs up behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_valid_q))
    else $error("request stalled without a held result");

  // no direction code outside -1..1 is ever delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (direction_o != 2'sb10))
    else $error("invalid direction code");

endmodule

### sim/tb.sv
// tb: self-checking bench for rotary_encoder_button_decoder, with its own
// encoder, debounce and click predictor, directed samples and random walks.
// Depends on rebd_pkg and the decoder RTL only.

module tb;
  import rebd_pkg::*;

  // one request as driven on the ports
  typedef struct packed {
    logic        pin_a;
    logic        pin_b;
    logic        button;
    logic [31:0] now;
    logic        read_events;
  } sample_t;

  // one result
  typedef struct packed {
    logic signed [1:0] dir;
    logic              clicked;
    logic              long_press;
    logic              double_click;
  } events_t;

  // directed row: request plus an optional typed-in result
  typedef struct packed {
    sample_t s;
    logic    typed;
    events_t ev;
  } probe_t;

  localparam events_t NoEv = '{DirNone, 1'b0, 1'b0, 1'b0};
  localparam logic [CfgIdxWidth-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CfgSpareHi = 3'd7;
  localparam int IdleLimit = 5000;
  localparam int MaxLogged = 40;
  localparam int PhaseItems = 313;

  // quadrature count change for {previous pins, current pins}
  localparam int QuadStep [16] = '{ 0, -1,  1,  0,
                                    1,  0,  0, -1,
                                   -1,  0,  0,  1,
                                    0,  1, -1,  0};
  // pin pairs in clockwise order
  localparam logic [1:0] CwOrder [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

  // opening samples: reset state, rotation both ways, too-fast step,
  // pin jump, bounce, click, long press, double click, timestamp wrap
  localparam probe_t OpeningSamples [24] = '{
    '{'{1'b1, 1'b1, 1'b1, 32'd0,          1'b1}, 1'b1, NoEv},
    '{'{1'b1, 1'b1, 1'b0, 32'd60,         1'b0}, 1'b1, NoEv},
    '{'{1'b1, 1'b1, 1'b0, 32'd70,         1'b1}, 1'b1, '{DirNone, 1'b0, 1'b0, 1'b1}},
    '{'{1'b0, 1'b1, 1'b1, 32'd200,        1'b0}, 1'b1, NoEv},
    '{'{1'b0, 1'b0, 1'b1, 32'd210,        1'b0}, 1'b1, NoEv},
    '{'{1'b1, 1'b0, 1'b1, 32'd220,        1'b0}, 1'b1, NoEv},
    '{'{1'b1, 1'b1, 1'b1, 32'd230,        1'b1}, 1'b1, '{DirCw, 1'b0, 1'b0, 1'b0}},
    '{'{1'b1, 1'b0, 1'b1, 32'd240,        1'b0}, 1'b1, NoEv},
    '{'{1'b0, 1'b0, 1'b1, 32'd250,        1'b0}, 1'b1, NoEv},
    '{'{1'b0, 1'b1, 1'b1, 32'd260,        1'b0}, 1'b1, NoEv},
    '{'{1'b1, 1'b1, 1'b1, 32'd270,        1'b1}, 1'b0, NoEv},
    '{'{1'b0, 1'b0, 1'b1, 32'd400,        1'b0}, 1'b1, NoEv},
    '{'{1'b1, 1'b1, 1'b1, 32'd410,        1'b1}, 1'b0, NoEv},
    '{'{1'b1, 1'b1, 1'b0, 32'd1000,       1'b0}, 1'b1, NoEv},
    '{'{1'b1, 1'b1, 1'b1, 32'd1020,       1'b0}, 1'b1, NoEv},
    '{'{1'b1, 1'b1, 1'b1, 32'd1100,       1'b1}, 1'b0, NoEv},
    '{'{1'b1, 1'b1, 1'b0, 32'd2000,       1'b0}, 1'b1, NoEv},
    '{'{1'b1, 1'b1, 1'b0, 32'd2900,       1'b1}, 1'b0, NoEv},
    '{'{1'b1, 1'b1, 1'b1, 32'd3000,       1'b0}, 1'b1, NoEv},
    '{'{1'b1, 1'b1, 1'b0, 32'd3100,       1'b0}, 1'b1, NoEv},
    '{'{1'b1, 1'b1, 1'b1, 32'd3200,       1'b0}, 1'b1, NoEv},
    '{'{1'b1, 1'b1, 1'b0, 32'd3300,       1'b1}, 1'b0, NoEv},
    '{'{1'b0, 1'b1, 1'b1, 32'hFFFF_FFF0,  1'b0}, 1'b1, NoEv},
    '{'{1'b0, 1'b0, 1'b1, 32'h0000_0010,  1'b1}, 1'b0, NoEv}
  };

  // ports
  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_stall_o;
  logic                    pin_a_i        = 1'b1;
  logic                    pin_b_i        = 1'b1;
  logic                    button_level_i = 1'b1;
  logic [NowWidth-1:0]     now_ms_i       = '0;
  logic                    read_events_i  = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i    = 1'b0;
  logic signed [1:0]       direction_o;
  logic                    clicked_o;
  logic                    long_press_o;
  logic                    double_click_o;
  logic                    cfg_valid_i    = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i    = '0;
  logic [CfgDataWidth-1:0] cfg_data_i     = '0;

  // typed-in result travelling with the request
  logic    req_typed    = 1'b0;
  events_t req_typed_ev = NoEv;

  // predictor settings
  logic [MsWidth-1:0]  m_step_ms  = StepIntervalRst;
  logic [MsWidth-1:0]  m_deb_ms   = DebounceRst;
  logic [MsWidth-1:0]  m_click_ms = ClickMaxRst;
  logic [MsWidth-1:0]  m_long_ms  = LongPressRst;
  logic [MsWidth-1:0]  m_dbl_ms   = DoubleClickRst;
  logic [ThrWidth-1:0] m_thresh   = StepThrRst;

  // predictor state
  logic [1:0]        m_prev       = EncIdle;
  int                m_count      = 0;
  logic [31:0]       m_step_t     = '0;
  logic signed [1:0] m_dir        = DirNone;
  logic              m_stable     = 1'b1;
  logic [31:0]       m_change_t   = '0;
  logic [31:0]       m_press_t    = '0;
  logic [31:0]       m_last_press = '0;
  logic              m_long_fired = 1'b0;
  logic              m_suppress   = 1'b0;
  logic              m_click_flag = 1'b0;
  logic              m_long_flag  = 1'b0;
  logic              m_dbl_flag   = 1'b0;

  events_t events_due [$];
  int      errors     = 0;
  int      idle_count = 0;
  bit      no_gaps    = 1'b0;

  // random walk state
  logic [1:0]  enc_pos   = 2'd0;
  logic [1:0]  enc_dir   = 2'd1;
  logic [31:0] now_t     = 32'h10;
  logic        btn_up    = 1'b1;
  logic [31:0] btn_since = '0;
  logic [31:0] btn_hold  = 32'd100;

  rotary_encoder_button_decoder DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] since(input logic [31:0] t_now, input logic [31:0] t_ref);
    return t_now - t_ref;
  endfunction

  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(0, 99) < 20);
  endfunction

  // predictor: advance encoder and button state by one sample
  function automatic events_t decode_sample(input sample_t s);
    logic [1:0] cur;
    int         thr;
    events_t    ev;
    cur = {s.pin_a, s.pin_b};
    thr = (m_thresh == '0) ? 1 : int'(m_thresh);

    // quadrature count and step latch
    m_count += QuadStep[{m_prev, cur}];
    m_prev = cur;
    if (m_count >= thr || m_count <= -thr) begin
      if (since(s.now, m_step_t) >= m_step_ms) begin
        m_step_t = s.now;
        m_dir = (m_count > 0) ? DirCw : DirCcw;
      end
      m_count = 0;
    end

    // debounced edges
    if (s.button != m_stable && since(s.now, m_change_t) >= m_deb_ms) begin
      m_change_t = s.now;
      m_stable = s.button;
      if (!s.button) begin
        m_press_t = s.now;
        m_long_fired = 1'b0;
        if (since(s.now, m_last_press) < m_dbl_ms) begin
          m_dbl_flag = 1'b1;
          m_click_flag = 1'b0;
          m_suppress = 1'b1;
        end
        m_last_press = s.now;
      end else begin
        if (!m_long_fired && since(s.now, m_press_t) < m_click_ms) begin
          if (!m_suppress) m_click_flag = 1'b1;
          m_suppress = 1'b0;
        end
        m_long_fired = 1'b0;
      end
    end

    // long press while held
    if (!m_stable && !m_long_fired && since(s.now, m_press_t) >= m_long_ms) begin
      m_long_flag = 1'b1;
      m_long_fired = 1'b1;
    end

    // report and clear on read
    ev = NoEv;
    if (s.read_events) begin
      ev = '{m_dir, m_click_flag, m_long_flag, m_dbl_flag};
      m_dir = DirNone;
      m_click_flag = 1'b0;
      m_long_flag = 1'b0;
      m_dbl_flag = 1'b0;
    end
    return ev;
  endfunction

  task automatic flag_error(input string msg);
    if (errors < MaxLogged) $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // drive one request and hold it until taken
  task automatic send_sample(input sample_t s, input logic typed, input events_t ev);
    while (take_gap()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pin_a_i        <= s.pin_a;
    pin_b_i        <= s.pin_b;
    button_level_i <= s.button;
    now_ms_i       <= s.now;
    read_events_i  <= s.read_events;
    req_typed      <= typed;
    req_typed_ev   <= ev;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // caller lowers cfg_valid_i after the last write
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // drain, then rewrite every register plus the unused indexes
  task automatic apply_settings(input logic [15:0] step_ms, input logic [15:0] deb_ms,
                                input logic [15:0] click_ms, input logic [15:0] long_ms,
                                input logic [15:0] dbl_ms, input logic [3:0] thr);
    in_valid_i <= 1'b0;
    // let the last accepted request be queued before checking the queue
    @(posedge clk_i);
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(CFG_STEP_INTERVAL, step_ms);
    write_reg(CfgSpareLo, 16'($urandom));
    write_reg(CFG_DEBOUNCE, deb_ms);
    write_reg(CFG_CLICK_MAX, click_ms);
    write_reg(CFG_LONG_PRESS, long_ms);
    write_reg(CFG_DOUBLE_CLICK, dbl_ms);
    write_reg(CFG_STEP_THRESH, {12'($urandom), thr});
    write_reg(CfgSpareHi, 16'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_settings();
    apply_settings(16'($urandom_range(0, 120)), 16'($urandom_range(0, 60)),
                   16'($urandom_range(50, 700)), 16'($urandom_range(100, 1500)),
                   16'($urandom_range(50, 600)), 4'($urandom_range(1, 15)));
  endtask

  // random walk: encoder mostly turning one way, button held and released
  // for plausible times with occasional bounce, rare large time jumps
  task automatic run_random(input int count);
    sample_t s;
    int      m;
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) now_t += $urandom;
      else now_t += $urandom_range(0, 40);

      m = $urandom_range(0, 15);
      if (m >= 5 && m < 13) enc_pos += enc_dir;
      else if (m >= 13 && m < 15) enc_pos -= enc_dir;
      else if (m == 15) enc_pos += 2'd2;
      if ($urandom_range(0, 19) == 0) enc_dir = -enc_dir;

      if (since(now_t, btn_since) >= btn_hold) begin
        btn_up = !btn_up;
        btn_since = now_t;
        if (btn_up) btn_hold = $urandom_range(30, 700);
        else if ($urandom_range(0, 3) == 0) btn_hold = $urandom_range(600, 1500);
        else btn_hold = $urandom_range(20, 450);
      end

      {s.pin_a, s.pin_b} = CwOrder[enc_pos];
      s.button = ($urandom_range(0, 9) == 0) ? !btn_up : btn_up;
      s.now = now_t;
      s.read_events = ($urandom_range(0, 3) == 0);
      send_sample(s, 1'b0, NoEv);
    end
  endtask

  // result side stalls
  always @(posedge clk_i) begin
    out_stall_i <= take_gap();
  end

  // accepted request: predict its result
  always @(posedge clk_i) begin : request_monitor
    events_t ev;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      ev = decode_sample('{pin_a_i, pin_b_i, button_level_i, now_ms_i, read_events_i});
      if (req_typed) ev = req_typed_ev;
      events_due.push_back(ev);
    end
  end

  // accepted register write: mirror it
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_STEP_INTERVAL: m_step_ms  = cfg_data_i;
        CFG_DEBOUNCE:      m_deb_ms   = cfg_data_i;
        CFG_CLICK_MAX:     m_click_ms = cfg_data_i;
        CFG_LONG_PRESS:    m_long_ms  = cfg_data_i;
        CFG_DOUBLE_CLICK:  m_dbl_ms   = cfg_data_i;
        CFG_STEP_THRESH:   m_thresh   = cfg_data_i[ThrWidth-1:0];
        default: ;
      endcase
    end
  end

  // accepted result: compare with the oldest prediction
  always @(posedge clk_i) begin : result_check
    events_t exp_ev;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (events_due.size() == 0) begin
        flag_error("result with no request pending");
      end else begin
        exp_ev = events_due.pop_front();
        if (direction_o !== exp_ev.dir)
          flag_error($sformatf("direction %0d, expected %0d", direction_o, exp_ev.dir));
        if (clicked_o !== exp_ev.clicked)
          flag_error($sformatf("clicked %b, expected %b", clicked_o, exp_ev.clicked));
        if (long_press_o !== exp_ev.long_press)
          flag_error($sformatf("long_press %b, expected %b", long_press_o,
                               exp_ev.long_press));
        if (double_click_o !== exp_ev.double_click)
          flag_error($sformatf("double_click %b, expected %b", double_click_o,
                               exp_ev.double_click));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_count <= 0;
    end else if (idle_count >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // main sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed samples under reset settings
    foreach (OpeningSamples[i])
      send_sample(OpeningSamples[i].s, OpeningSamples[i].typed, OpeningSamples[i].ev);

    random_settings();
    run_random(PhaseItems);

    // all zero, threshold zero behaves as one
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0);
    run_random(PhaseItems);

    // all at maximum
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    run_random(PhaseItems);

    // back-to-back stretch with no gaps on either side
    random_settings();
    no_gaps = 1'b1;
    run_random(PhaseItems);
    no_gaps = 1'b0;

    apply_settings(StepIntervalRst, DebounceRst, ClickMaxRst, LongPressRst,
                   DoubleClickRst, StepThrRst);
    run_random(PhaseItems);

    random_settings();
    run_random(PhaseItems);

    // drain and settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (events_due.size() != 0) flag_error("predicted results left over");

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
